>>> rtl/ptt_pkg.sv
// Shared types, operation codes and constants of the periodic task timer table.
package ptt_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 8;
   localparam int PERIOD_W = 32;
   localparam int TICK_W   = 8;

   localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_USER    = 2'd3;

   localparam logic TRIG_PERIODIC = 1'b0;
   localparam logic TRIG_USER     = 1'b1;

   localparam logic [TICK_W-1:0] MS_PER_TICK_RESET = 8'd2;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic                trig;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] elapsed;
   } entry_type;

endpackage

>>> rtl/periodic_task_timer_table_top.sv
// Top level of the periodic task timer table: cell ring, walk control and result register.
// Every transaction walks the whole table once: the ring of MAX_TASKS cells rotates one
// entry per cycle past a single update unit at its head, except while a new firing waits
// on a stalled result channel; a closing flush state follows the walk. Create appends at
// the current fill count, destroy drops the first matching entry and closes the gap on the
// way, tick and user-input transactions emit one result per due entry in table order, the
// final one flagged with rsp_last. req_stall is high for the whole walk. The tick length may
// be written through the csr port whenever the block is idle; csr_ready is always high.
module periodic_task_timer_table_top #(
   parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ptt_pkg::KIND_W-1:0]     req_kind,
   input  logic [ptt_pkg::ID_W-1:0]       req_task_id,
   input  logic                           req_task_kind,
   input  logic [ptt_pkg::PERIOD_W-1:0]   req_period_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ptt_pkg::ID_W-1:0]       rsp_fired_id,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptt_pkg::TICK_W-1:0]     csr_ms_per_tick
);

   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int STEP_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int NXT    = (MAX_TASKS > 1) ? 1 : 0;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_TASKS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         found_ff, found_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [ptt_pkg::ID_W-1:0]     pend_id_ff, pend_id_in;
   logic [ptt_pkg::TICK_W-1:0]   ms_per_tick_ff;
   logic                         rsp_valid_ff;
   logic [ptt_pkg::ID_W-1:0]     rsp_id_ff;
   logic                         rsp_last_ff;

   logic [ptt_pkg::KIND_W-1:0]   op_kind_ff;
   ptt_pkg::entry_type           op_entry_ff;

   ptt_pkg::entry_type cell_q [MAX_TASKS];
   ptt_pkg::entry_type tail_in;
   ptt_pkg::entry_type proc_in;
   ptt_pkg::entry_type proc_out;

   logic                     accept;
   logic                     shift_en;
   logic                     active;
   logic                     fire;
   logic                     drop;
   logic                     out_free;
   logic                     push;
   logic [ptt_pkg::ID_W-1:0] push_id;
   logic                     push_last;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign active = ({{(CNT_W-STEP_W){1'b0}}, step_ff} < count_ff) && (state_ff == ST_WALK);
   assign drop   = active && (op_kind_ff == ptt_pkg::KIND_DESTROY) && !found_ff
                   && (cell_q[0].id == op_entry_ff.id);

   // Once the destroyed entry has passed the head, the tail is fed from the second cell so
   // that every later entry lands one place lower when the ring has come full circle.
   assign proc_in = (drop || found_ff) ? cell_q[NXT] : cell_q[0];

   ptt_proc u_proc (
      .op_kind     (op_kind_ff),
      .ms_per_tick (ms_per_tick_ff),
      .active      (active),
      .entry_in    (proc_in),
      .entry_out   (proc_out),
      .fire        (fire)
   );

   always_comb begin
      tail_in = proc_out;
      if ((op_kind_ff == ptt_pkg::KIND_CREATE) && (count_ff < CNT_FULL)
          && ({{(CNT_W-STEP_W){1'b0}}, step_ff} == count_ff)) begin
         tail_in = op_entry_ff;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         ptt_pkg::entry_type cell_d;
         if (g == MAX_TASKS - 1) begin : g_tail
            assign cell_d = tail_in;
         end else begin : g_body
            assign cell_d = cell_q[g+1];
         end
         ptt_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .entry_in  (cell_d),
            .entry_out (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      shift_en      = 1'b0;
      push          = 1'b0;
      push_id       = pend_id_ff;
      push_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
               step_in  = '0;
               found_in = 1'b0;
            end
         end
         ST_WALK: begin
            // A new firing needs the previous pending result moved out first.
            if (!(fire && pend_valid_ff && !out_free)) begin
               shift_en = 1'b1;
               step_in  = step_ff + STEP_W'(1);
               if (drop) begin
                  found_in = 1'b1;
               end
               if (fire) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_id_in    = proc_in.id;
               end
               if (step_ff == STEP_LAST) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  push          = 1'b1;
                  push_last     = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
            if (state_in == ST_IDLE) begin
               if ((op_kind_ff == ptt_pkg::KIND_CREATE) && (count_ff < CNT_FULL)) begin
                  count_in = count_ff + CNT_W'(1);
               end else if ((op_kind_ff == ptt_pkg::KIND_DESTROY) && found_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         step_ff        <= '0;
         found_ff       <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ms_per_tick_ff <= ptt_pkg::MS_PER_TICK_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_ready) begin
            ms_per_tick_ff <= csr_ms_per_tick;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      if (push) begin
         rsp_id_ff   <= push_id;
         rsp_last_ff <= push_last;
      end
      if (accept) begin
         op_kind_ff          <= req_kind;
         op_entry_ff.id      <= req_task_id;
         op_entry_ff.trig    <= req_task_kind;
         op_entry_ff.period  <= req_period_ms;
         op_entry_ff.elapsed <= '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

>>> rtl/ptt_cell.sv
// One table cell: holds a timer entry and loads its neighbor's entry on a shift.
module ptt_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  ptt_pkg::entry_type  entry_in,
   output ptt_pkg::entry_type  entry_out
);

   ptt_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

>>> rtl/ptt_proc.sv
// Per-entry update unit: advances the elapsed counter on a tick and decides whether the entry fires.
module ptt_proc (
   input  logic [ptt_pkg::KIND_W-1:0]  op_kind,
   input  logic [ptt_pkg::TICK_W-1:0]  ms_per_tick,
   input  logic                        active,
   input  ptt_pkg::entry_type          entry_in,
   output ptt_pkg::entry_type          entry_out,
   output logic                        fire
);

   logic [ptt_pkg::PERIOD_W:0]   sum;
   logic [ptt_pkg::PERIOD_W-1:0] elapsed_sat;
   logic [ptt_pkg::PERIOD_W-1:0] elapsed_new;
   logic                         trig_match;

   always_comb begin
      sum = {1'b0, entry_in.elapsed} + {{(ptt_pkg::PERIOD_W+1-ptt_pkg::TICK_W){1'b0}}, ms_per_tick};
      elapsed_sat = sum[ptt_pkg::PERIOD_W] ? {ptt_pkg::PERIOD_W{1'b1}}
                                           : sum[ptt_pkg::PERIOD_W-1:0];
      elapsed_new = entry_in.elapsed;
      trig_match  = 1'b0;
      case (op_kind)
         ptt_pkg::KIND_TICK: begin
            elapsed_new = elapsed_sat;
            trig_match  = (entry_in.trig == ptt_pkg::TRIG_PERIODIC);
         end
         ptt_pkg::KIND_USER: begin
            trig_match  = (entry_in.trig == ptt_pkg::TRIG_USER);
         end
         default: begin
            trig_match  = 1'b0;
         end
      endcase
      fire      = active && trig_match && (elapsed_new >= entry_in.period);
      entry_out = entry_in;
      if (active) begin
         entry_out.elapsed = fire ? '0 : elapsed_new;
      end
   end

endmodule

>>> rtl/ptt_checker.sv
// Port-level checks of the periodic task timer table and their binding to the top level.
module ptt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [ptt_pkg::ID_W-1:0]   rsp_fired_id,
   input logic                       rsp_last
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fired_id) && $stable(rsp_last)))
      else $error("stalled result changed");

   // Every accepted transaction starts a walk that blocks further requests.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open right after an accepted transaction");

   // Results come only from the walk and its flush, so none rises in the cycle after acceptance.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared before the walk began");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_task_timer_table_top ptt_checker u_ptt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_fired_id (rsp_fired_id),
   .rsp_last     (rsp_last)
);
